@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the band-pass mix block.
// Defining ASSERT_OFF turns every assertion into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

@@ src/svbm_pkg.sv @@
// Types and constants of the state-variable band-pass mix block.
// Used by svbm_mul and state_variable_bandpass_mix; depends on nothing.
package svbm_pkg;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [1:0] {
    REG_FREQ_COEF    = 2'd0,
    REG_DAMPING      = 2'd1,
    REG_TARGET_BLEND = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] FREQ_COEF_RST    = 16'd4284;
  localparam logic [15:0] DAMPING_RST      = 16'd3277;
  localparam logic [15:0] TARGET_BLEND_RST = 16'd19661;
  localparam logic [15:0] TARGET_MAX       = 16'd32768;
  localparam logic [31:0] BLEND_RST        = 32'd1288490189;
  localparam logic [31:0] BLEND_ONE        = 32'd2147483648;
  localparam logic signed [MUL_A_W-1:0] SMOOTH_K = 24'sd2147484;

endpackage

@@ src/svbm_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on svbm_pkg for the operand widths and the request struct.
module svbm_mul (
  input  logic                                clk,
  input  svbm_pkg::mul_req_t                  req,
  output logic signed [svbm_pkg::PROD_W-1:0]  prod
);
  import svbm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= req.a * req.b;
    end
  end

  assign prod = prod_r;

endmodule

@@ src/state_variable_bandpass_mix.sv @@
// State-variable band-pass filter with a smoothed wet/dry mix, one sample of one channel per
// word. All products go through one 24 x 33 bit multiplier whose result is registered before
// use, so a word for a valid channel runs from S_DAMP_MUL through S_OUT before the next is
// accepted; with frame_start set, S_BLEND_MUL and S_BLEND_ADD run first for the blend smoother
// step. A word for a channel at or above CHANNELS skips the filter and passes through unfiltered.
// The result waits in an output register, and the next word is taken while it waits; the final
// step of a word stalls only while that register still holds an unaccepted result.
`include "assert_macros.svh"

module state_variable_bandpass_mix #(
  parameter int CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_in,
  input  logic [3:0]         in_chan,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  output logic [3:0]         out_chan_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import svbm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLEND_MUL,
    S_BLEND_ADD,
    S_DAMP_MUL,
    S_HIGH,
    S_BAND_MUL,
    S_BAND,
    S_LOW_MUL,
    S_LOW,
    S_MIX_DRY,
    S_MIX_SUM,
    S_OUT
  } state_t;

  state_t                    state_r;
  logic [15:0]               freq_coef_r;
  logic [15:0]               damping_r;
  logic [15:0]               target_r;
  logic [31:0]               cb_r;
  logic signed [MUL_B_W-1:0] diff_r;
  logic signed [MUL_B_W-1:0] dry_r;
  logic signed [23:0]        band_mem_r [CHANNELS];
  logic signed [23:0]        low_mem_r [CHANNELS];

  logic signed [15:0]        x_r;
  logic [3:0]                chan_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      in_range_r;
  logic signed [23:0]        band_r;
  logic signed [23:0]        low_r;
  logic signed [23:0]        high_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic                      out_valid_r;
  logic signed [15:0]        out_sample_r;
  logic [3:0]                out_chan_r;

  mul_req_t                  mul_req;
  logic signed [PROD_W-1:0]  prod;

  logic                      in_fire;
  logic                      in_chan_ok;
  logic [IDX_W-1:0]          in_idx;
  logic                      out_free;
  logic                      wb_en;
  logic [15:0]               target_clamped;
  logic signed [MUL_A_W-1:0] xq;
  logic signed [PROD_W-1:0]  r15_full;
  logic signed [PROD_W-1:0]  r31_full;
  logic signed [PROD_W-1:0]  r37_full;
  logic signed [43:0]        r15;
  logic signed [43:0]        xq_ext;
  logic signed [43:0]        low_ext;
  logic signed [43:0]        band_ext;
  logic signed [33:0]        cb_sum;
  logic signed [23:0]        high_nxt;
  logic signed [23:0]        band_nxt;
  logic signed [23:0]        low_nxt;
  logic [31:0]               cb_nxt;
  logic signed [15:0]        y_nxt;

  function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
    logic signed [23:0] r;
    if (v > 44'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -44'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  svbm_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_chan_ok = ({1'b0, in_chan} < 5'(CHANNELS));
  assign in_idx     = in_chan_ok ? in_chan[IDX_W-1:0] : '0;
  assign out_free   = !out_valid_r || out_ready;
  assign wb_en      = (state_r == S_OUT) && out_free && in_range_r;
  assign cfg_ready  = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_chan_out   = out_chan_r;

  assign target_clamped = (target_r > TARGET_MAX) ? TARGET_MAX : target_r;
  assign xq = {{2{x_r[15]}}, x_r, 6'b0};

  always_comb begin
    r15_full = (prod + 57'sd16384) >>> 15;
    r31_full = (prod + 57'sd1073741824) >>> 31;
    r37_full = (acc_r + 57'sd68719476736) >>> 37;
    r15      = signed'(r15_full[43:0]);
    xq_ext   = {{20{xq[23]}}, xq};
    low_ext  = {{20{low_r[23]}}, low_r};
    band_ext = {{20{band_r[23]}}, band_r};
    high_nxt = sat24(xq_ext - low_ext - r15);
    band_nxt = sat24(band_ext + r15);
    low_nxt  = sat24(low_ext + r15);
    cb_sum   = signed'({2'b00, cb_r}) + signed'(r31_full[33:0]);
    if (cb_sum < 34'sd0) begin
      cb_nxt = '0;
    end else if (cb_sum > signed'({2'b00, BLEND_ONE})) begin
      cb_nxt = BLEND_ONE;
    end else begin
      cb_nxt = cb_sum[31:0];
    end
    y_nxt = in_range_r ? sat16(signed'(r37_full[23:0])) : x_r;
  end

  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = band_r;
    mul_req.b  = signed'({17'b0, freq_coef_r});
    unique case (state_r)
      S_BLEND_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = SMOOTH_K;
        mul_req.b  = diff_r;
      end
      S_DAMP_MUL: begin
        mul_req.en = 1'b1;
        mul_req.b  = signed'({17'b0, damping_r});
      end
      S_BAND_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = high_r;
      end
      S_LOW_MUL: begin
        mul_req.en = 1'b1;
      end
      S_LOW: begin
        mul_req.en = 1'b1;
        mul_req.b  = signed'({1'b0, cb_r});
      end
      S_MIX_DRY: begin
        mul_req.en = 1'b1;
        mul_req.a  = xq;
        mul_req.b  = dry_r;
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_coef_r <= FREQ_COEF_RST;
      damping_r   <= DAMPING_RST;
      target_r    <= TARGET_BLEND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FREQ_COEF:    freq_coef_r <= cfg_data;
        REG_DAMPING:      damping_r   <= cfg_data;
        REG_TARGET_BLEND: target_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= signed'({1'b0, target_clamped, 16'b0}) - signed'({1'b0, cb_r});
    dry_r  <= signed'({1'b0, BLEND_ONE}) - signed'({1'b0, cb_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        band_mem_r[i] <= '0;
        low_mem_r[i]  <= '0;
      end
    end else if (wb_en) begin
      band_mem_r[idx_r] <= band_r;
      low_mem_r[idx_r]  <= low_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cb_r        <= BLEND_RST;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r        <= in_sample_in;
            chan_r     <= in_chan;
            idx_r      <= in_idx;
            in_range_r <= in_chan_ok;
            band_r     <= band_mem_r[in_idx];
            low_r      <= low_mem_r[in_idx];
            if (in_frame_start) begin
              state_r <= S_BLEND_MUL;
            end else if (in_chan_ok) begin
              state_r <= S_DAMP_MUL;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_BLEND_MUL: begin
          state_r <= S_BLEND_ADD;
        end
        S_BLEND_ADD: begin
          cb_r    <= cb_nxt;
          state_r <= in_range_r ? S_DAMP_MUL : S_OUT;
        end
        S_DAMP_MUL: begin
          state_r <= S_HIGH;
        end
        S_HIGH: begin
          high_r  <= high_nxt;
          state_r <= S_BAND_MUL;
        end
        S_BAND_MUL: begin
          state_r <= S_BAND;
        end
        S_BAND: begin
          band_r  <= band_nxt;
          state_r <= S_LOW_MUL;
        end
        S_LOW_MUL: begin
          state_r <= S_LOW;
        end
        S_LOW: begin
          low_r   <= low_nxt;
          state_r <= S_MIX_DRY;
        end
        S_MIX_DRY: begin
          acc_r   <= prod;
          state_r <= S_MIX_SUM;
        end
        S_MIX_SUM: begin
          acc_r   <= acc_r + prod;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= y_nxt;
            out_chan_r   <= chan_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_RST(a_busy_after_accept, clk, rst_n, in_fire |=> !in_ready, "accepted a word while busy")
  `ASSERT_RST(a_blend_bound, clk, rst_n, cb_r <= BLEND_ONE, "blend above one")
  `ASSERT_RST(a_out_from_out_state, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUT), "result raised outside output step")
  `ASSERT_RST(a_blend_update_step, clk, rst_n, !$stable(cb_r) |-> $past(state_r == S_BLEND_ADD), "blend changed outside smoother step")

endmodule

@@ tb/sv/tb_state_variable_bandpass_mix.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for state_variable_bandpass_mix. It streams audio words and register
// writes under changing idle patterns and checks every mixed word against a fixed-point model.
// Depends on svbm_pkg and the block's RTL only.
module tb_state_variable_bandpass_mix;
  import svbm_pkg::*;

  localparam int CHANNELS = 2;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 150;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam longint Q24_MAX = 64'sd8388607;
  localparam longint Q24_MIN = -64'sd8388608;
  localparam longint UNITY_31 = 64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] smp;
    logic [3:0]         ch;
  } mix_word_t;

  typedef struct {
    logic signed [15:0] smp;
    logic [3:0]         ch;
    logic               fs;
    bit                 typed;
    logic signed [15:0] out;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_sample_in;
  logic [3:0]         in_chan;
  logic               in_frame_start;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_sample_out;
  logic [3:0]         out_chan_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  logic [15:0]        coef_cfg;
  logic [15:0]        damp_cfg;
  logic [15:0]        wet_target_cfg;
  logic [31:0]        wet_blend;
  logic signed [23:0] band_acc [CHANNELS];
  logic signed [23:0] low_acc [CHANNELS];
  mix_word_t          due_q[$];
  dir_row_t           dir_rows [20];

  int fail_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int bypass_count = 0;
  int settings_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int squeeze_done = 0;
  bit squeeze_req = 1'b0;

  always #10 clk = ~clk;

  state_variable_bandpass_mix #(
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .in_chan       (in_chan),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_chan_out  (out_chan_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint rshift_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void reset_filter_model();
    coef_cfg = FREQ_COEF_RST;
    damp_cfg = DAMPING_RST;
    wet_target_cfg = TARGET_BLEND_RST;
    wet_blend = BLEND_RST;
    for (int c = 0; c < CHANNELS; c++) begin
      band_acc[c] = '0;
      low_acc[c] = '0;
    end
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_FREQ_COEF: coef_cfg = val;
      REG_DAMPING: damp_cfg = val;
      REG_TARGET_BLEND: wet_target_cfg = val;
      default: ;
    endcase
  endfunction

  // One filter update plus wet/dry mix (pass-through if ch >= CHANNELS); blend smoother steps first on frame start.
  function automatic mix_word_t svf_step(logic signed [15:0] smp, logic [3:0] ch, logic fs);
    longint xq, bd, lo, hp, fc, dm, cb, goal, k, y;
    mix_word_t r;
    if (fs) begin
      goal = longint'((wet_target_cfg > TARGET_MAX) ? TARGET_MAX : wet_target_cfg);
      goal = goal * 65536;
      cb = longint'(wet_blend);
      k = longint'(SMOOTH_K);
      cb = clip(cb + rshift_round((goal - cb) * k, 31), 0, UNITY_31);
      wet_blend = cb[31:0];
    end
    r.ch = ch;
    if (ch < CHANNELS) begin
      xq = longint'(smp);
      xq = xq * 64;
      bd = longint'(band_acc[ch]);
      lo = longint'(low_acc[ch]);
      fc = longint'(coef_cfg);
      dm = longint'(damp_cfg);
      hp = clip(xq - lo - rshift_round(dm * bd, 15), Q24_MIN, Q24_MAX);
      bd = clip(bd + rshift_round(fc * hp, 15), Q24_MIN, Q24_MAX);
      lo = clip(lo + rshift_round(fc * bd, 15), Q24_MIN, Q24_MAX);
      band_acc[ch] = bd[23:0];
      low_acc[ch] = lo[23:0];
      cb = longint'(wet_blend);
      y = clip(rshift_round(bd * cb + xq * (UNITY_31 - cb), 37), -32768, 32767);
      r.smp = y[15:0];
    end else begin
      r.smp = smp;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(512) - 256);
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic offer_word(input logic signed [15:0] smp, input logic [3:0] ch,
                            input logic fs, input bit typed,
                            input logic signed [15:0] typed_out);
    mix_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_chan <= ch;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    w = svf_step(smp, ch, fs);
    if (typed) begin
      w.smp = typed_out;
    end
    due_q.push_back(w);
    words_sent++;
    if (ch >= CHANNELS) begin
      bypass_count++;
    end
    @(negedge clk);
  endtask

  // The spare index is written with random data in between; the block must ignore it.
  task automatic write_settings(input logic [15:0] coef, input logic [15:0] damp,
                                input logic [15:0] target);
    logic [1:0] idx [4];
    logic [15:0] val [4];
    idx = '{REG_FREQ_COEF, REG_DAMPING, REG_SPARE, REG_TARGET_BLEND};
    val = '{coef, damp, 16'($urandom_range(16'hffff)), target};
    @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && squeeze_done < SQUEEZE_CYCLES) begin
        out_ready <= 1'b0;
        squeeze_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_words
    mix_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (due_q.size() == 0) begin
        $display("%0t: unexpected word, sample_out %0d chan_out %0d", $time,
                 out_sample_out, out_chan_out);
        fail_count++;
      end else begin
        w = due_q.pop_front();
        if (out_sample_out !== w.smp) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, w.smp, out_sample_out);
          fail_count++;
        end
        if (out_chan_out !== w.ch) begin
          $display("%0t: chan_out expected %0d actual %0d", $time, w.ch, out_chan_out);
          fail_count++;
        end
        words_checked++;
      end
    end
  end

  initial begin : run
    int sent;
    logic [15:0] coef, damp, target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    in_chan = '0;
    in_frame_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FREQ_COEF;
    cfg_data = '0;
    dir_rows = '{
      '{0, 0, 0, 1, 0},
      '{0, 1, 0, 1, 0},
      '{32767, 0, 0, 0, 0},
      '{32767, 0, 0, 0, 0},
      '{-32768, 0, 0, 0, 0},
      '{-32768, 1, 1, 0, 0},
      '{32767, 1, 1, 0, 0},
      '{1234, 2, 0, 1, 1234},
      '{-32768, 15, 1, 1, -32768},
      '{32767, 15, 0, 1, 32767},
      '{-1, 3, 1, 1, -1},
      '{0, 0, 1, 0, 0},
      '{-1, 1, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{32767, 0, 1, 0, 0},
      '{32767, 1, 0, 0, 0},
      '{21845, 8, 0, 1, 21845},
      '{-21846, 7, 1, 1, -21846},
      '{-32768, 0, 0, 0, 0},
      '{-32768, 1, 0, 0, 0}
    };
    reset_filter_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      offer_word(dir_rows[i].smp, dir_rows[i].ch, dir_rows[i].fs, dir_rows[i].typed,
                 dir_rows[i].out);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      while (due_q.size() != 0) @(posedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      squeeze_req = squeeze_req | (ph == 4);
      case (ph)
        0: begin coef = FREQ_COEF_RST; damp = DAMPING_RST; target = TARGET_BLEND_RST; end
        1: begin coef = 16'hffff; damp = 16'hffff; target = 16'hffff; end
        2: begin coef = 16'd0; damp = 16'd0; target = 16'd0; end
        3: begin coef = 16'd32768; damp = DAMPING_RST; target = TARGET_MAX; end
        5: begin coef = 16'd12000; damp = 16'd32768; target = 16'd40000; end
        7: begin coef = 16'd1000; damp = 16'd8000; target = 16'd16384; end
        default: begin
          coef = 16'($urandom_range(16'hffff));
          damp = 16'($urandom_range(16'hffff));
          target = 16'($urandom_range(16'hffff));
        end
      endcase
      write_settings(coef, damp, target);

      // Mostly whole frames in channel order; the rest are stray words on any channel.
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(99) < 85) begin
          for (int c = 0; c < CHANNELS; c++) begin
            offer_word(pick_sample(), 4'(c), c == 0, 1'b0, '0);
          end
          sent += CHANNELS;
        end else begin
          offer_word(pick_sample(), 4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, '0);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d audio words (%0d bypassed) over %0d register settings; %0d compared.",
             words_sent, bypass_count, settings_count, words_checked);
    $display("Idle patterns: none, sender-heavy, receiver-heavy, light on both, one long hold.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ state_variable_bandpass_mix.f @@
+incdir+src
src/svbm_pkg.sv
src/svbm_mul.sv
src/state_variable_bandpass_mix.sv
tb/sv/tb_state_variable_bandpass_mix.sv
